@@ hw/rtl/rht_pkg.sv @@
// ----------------------------------------------------------------------------
// rht_pkg
// shared status and command codes for the hole tracker
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

endpackage

@@ hw/rtl/rht_if.sv @@
// ----------------------------------------------------------------------------
// rht_if
// valid/ready channel carrying one beat of payload
// ----------------------------------------------------------------------------
interface rht_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/reassembly_hole_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// reassembly_hole_tracker_unit
// ordered hole table in one memory, walked and rebuilt per fragment
// ----------------------------------------------------------------------------
// clear and empty fragment: result beat in the cycle after acceptance; other
//   fragments search the table entry by entry (S_SRCH reads, S_SCHK checks),
//   then rebuild it in a read/write pass over the table memory (S_BRD, S_OUT)
// flow: one fragment at a time, the next one can be accepted in the cycle
//   after the result beat is taken
// reset: table holds one unbounded hole, count one; the memory is not cleared,
//   entries beyond the count are never read
module reassembly_hole_tracker_unit #(
    parameter int MAX_HOLES   = 8,
    parameter int OFFSET_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    rht_if.sink   in_ch,
    rht_if.source out_ch
);
    import rht_pkg::*;

    localparam int HB = OFFSET_BITS + 1;
    localparam int AW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CW = $clog2(MAX_HOLES + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_SCHK  = 3'd2;
    localparam logic [2:0] S_BUILD = 3'd3;
    localparam logic [2:0] S_BRD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [HB-1:0] mem_s [MAX_HOLES];
    logic [HB-1:0] mem_e [MAX_HOLES];
    logic [HB-1:0] rd_s, rd_e;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [HB-1:0] wr_s, wr_e;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_s[wr_addr] <= wr_s;
            mem_e[wr_addr] <= wr_e;
        end
        rd_s <= mem_s[rd_addr];
        rd_e <= mem_e[rd_addr];
    end

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] j_reg, j_next;     // read index
    logic [CW-1:0] k_reg, k_next;     // write index
    logic [CW-1:0] hit_reg, hit_next;
    logic [1:0]    phase_reg, phase_next; // 0 copy, 1 merge, 2 tail shift, 3 right piece
    logic [HB-1:0] off_reg, past_reg, last_reg;
    logic [HB-1:0] hend_reg;          // end of the hit hole before the rewrite
    logic          fin_reg;
    logic [1:0]    st_reg, st_next;
    logic          ov_reg, ov_next;
    logic          init_reg, init_next;

    logic [HB-1:0] off_w, past_w;
    assign off_w  = HB'(in_ch.data.frag_offset[OFFSET_BITS-1:0]);
    assign past_w = off_w + HB'(in_ch.data.frag_length[OFFSET_BITS-1:0]);

    assign in_ch.ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;

    logic hit;
    assign hit = (off_reg <= rd_e) && (last_reg >= rd_s);

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            off_reg  <= off_w;
            past_reg <= past_w;
            last_reg <= past_w - HB'(1);
            fin_reg  <= in_ch.data.is_final;
        end
        if (state_reg == S_BUILD)
            hend_reg <= rd_e;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        hit_next   = hit_reg;
        phase_next = phase_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        init_next  = 1'b0;
        rd_addr    = j_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = k_reg[AW-1:0];
        wr_s       = rd_s;
        wr_e       = rd_e;
        if (init_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_s    = '0;
            wr_e    = '1;
        end
        if (ov_reg && out_ch.ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    if (in_ch.data.command == CMD_CLEAR)
                    begin
                        init_next  = 1'b1;
                        count_next = CW'(1);
                        st_next    = ST_ACCEPTED;
                        ov_next    = 1'b1;
                    end
                    else if (in_ch.data.frag_length[OFFSET_BITS-1:0] == '0)
                    begin
                        st_next = ST_EMPTY;
                        ov_next = 1'b1;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                // issue read of entry j
                if (j_reg >= count_reg)
                begin
                    st_next    = ST_DUPLICATE;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (hit)
                begin
                    hit_next = j_reg;
                    if (!fin_reg && off_reg > rd_s && past_reg <= rd_e
                        && count_reg >= CW'(MAX_HOLES))
                    begin
                        st_next    = ST_FULL;
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // entries before hit stay in place; rewrite from hit
                        k_next     = j_reg;
                        state_next = S_BUILD;
                        phase_next = 2'd0;
                    end
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_SRCH;
                end
            end
            S_BUILD:
            begin
                // rd holds the hit hole; write its pieces
                // left piece at k (== hit); right piece needs a shift of the tail
                if (off_reg > rd_s)
                begin
                    wr_en  = 1'b1;
                    wr_s   = rd_s;
                    wr_e   = off_reg - HB'(1);
                    k_next = k_reg + CW'(1);
                end
                if (fin_reg)
                begin
                    count_next = (off_reg > rd_s) ? k_reg + CW'(1) : k_reg;
                    st_next    = ST_ACCEPTED;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else if (past_reg <= rd_e)
                begin
                    if (off_reg > rd_s)
                    begin
                        // split: shift tail up by one, from the top down
                        j_next     = count_reg - CW'(1);
                        phase_next = 2'd2;
                        state_next = S_BRD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_s       = past_reg;
                        wr_e       = rd_e;
                        st_next    = ST_ACCEPTED;
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    j_next     = hit_reg + CW'(1);
                    phase_next = 2'd1;
                    state_next = S_BRD;
                end
            end
            S_BRD:
            begin
                // issue read of j (of hit once the tail is shifted); S_OUT follows unless the pass ends
                if (phase_reg == 2'd2)
                begin
                    if (j_reg <= hit_reg)
                    begin
                        // tail shifted; place right piece of split hole
                        rd_addr    = hit_reg[AW-1:0];
                        j_next     = hit_reg;
                        phase_next = 2'd3;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_OUT;
                end
                else if (j_reg >= count_reg)
                begin
                    count_next = k_reg;
                    st_next    = ST_ACCEPTED;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                case (phase_reg)
                    2'd1:
                    begin
                        // merge: drop fully covered holes
                        if (((rd_s > past_reg) ? rd_s : past_reg) <= rd_e)
                        begin
                            wr_en = 1'b1;
                            wr_s  = (rd_s > past_reg) ? rd_s : past_reg;
                            k_next     = k_reg + CW'(1);
                            phase_next = 2'd0;
                        end
                        j_next     = j_reg + CW'(1);
                        state_next = S_BRD;
                    end
                    2'd0:
                    begin
                        wr_en      = 1'b1;
                        k_next     = k_reg + CW'(1);
                        j_next     = j_reg + CW'(1);
                        state_next = S_BRD;
                    end
                    2'd2:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(j_reg + CW'(1));
                        j_next     = j_reg - CW'(1);
                        state_next = S_BRD;
                    end
                    default:
                    begin
                        // original hit hole, now its right piece
                        wr_en      = 1'b1;
                        wr_addr    = AW'(hit_reg + CW'(1));
                        wr_s       = past_reg;
                        wr_e       = hend_reg;
                        count_next = count_reg + CW'(1);
                        st_next    = ST_ACCEPTED;
                        ov_next    = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            ov_reg    <= 1'b0;
            init_reg  <= 1'b1;
            st_reg    <= ST_ACCEPTED;
            j_reg     <= '0;
            k_reg     <= '0;
            hit_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            init_reg  <= init_next;
            st_reg    <= st_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            hit_reg   <= hit_next;
            phase_reg <= phase_next;
        end
    end

    assign out_ch.data.status     = st_reg;
    assign out_ch.data.complete   = (count_reg == '0);
    assign out_ch.data.holes_left = 4'(count_reg);

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_HOLES)) else $error("hole count over table size");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> ov_reg && $stable(st_reg))
        else $error("result dropped");
endmodule
